// ===== hdl/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg: shared types and constants for the 4x4 vector-matrix transform
// Item kinds, the control word that travels down the cell chain, and the
// default fixed-point format.
// ----------------------------------------------------------------------------
package vmt_pkg;

   localparam int WORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF  = 16;
   localparam int NUM_ROWS       = 4;
   localparam int NUM_COLS       = 4;

   typedef enum logic {
      REQ_LOAD  = 1'b0,
      REQ_XFORM = 1'b1
   } req_kind_type;

   // control word riding alongside each item in the chain
   typedef struct packed {
      logic         valid;
      req_kind_type kind;
      logic [1:0]   row;
      logic [1:0]   col;
   } ctl_type;

endpackage

// ===== hdl/vmt_cell.sv =====
// ----------------------------------------------------------------------------
// vmt_cell: one matrix row of the transform chain
// Holds row ROW of the matrix, multiplies the matching vector component by
// the four entries, and adds the products into the partial column sums
// handed on from the previous cell. Entry loads for this row are written as
// the load item passes, so items stay in order with respect to the matrix.
// ----------------------------------------------------------------------------
module vmt_cell
   import vmt_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int ROW        = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  ctl_type                             in_ctl,
   input  logic signed [WORD_WIDTH-1:0]        in_value,
   input  logic signed [WORD_WIDTH-1:0]        in_vec [NUM_ROWS],
   input  logic signed [2*WORD_WIDTH+1:0]      in_sum [NUM_COLS],
   output logic                                in_ready,
   output ctl_type                             out_ctl,
   output logic signed [WORD_WIDTH-1:0]        out_value,
   output logic signed [WORD_WIDTH-1:0]        out_vec [NUM_ROWS],
   output logic signed [2*WORD_WIDTH+1:0]      out_sum [NUM_COLS],
   input  logic                                out_ready
);

   localparam int PROD_W = 2 * WORD_WIDTH;
   localparam int ACC_W  = PROD_W + 2;
   localparam logic signed [WORD_WIDTH-1:0] ONE =
      {{(WORD_WIDTH-1){1'b0}}, 1'b1} << FRAC_BITS;

   logic signed [WORD_WIDTH-1:0] mat_ff [NUM_COLS];

   // multiply stage
   ctl_type                       a_ctl_ff;
   logic signed [WORD_WIDTH-1:0]  a_value_ff;
   logic signed [WORD_WIDTH-1:0]  a_vec_ff  [NUM_ROWS];
   logic signed [ACC_W-1:0]       a_sum_ff  [NUM_COLS];
   logic signed [PROD_W-1:0]      a_prod_ff [NUM_COLS];
   logic signed [PROD_W-1:0]      a_prod_in [NUM_COLS];

   // accumulate stage
   ctl_type                       b_ctl_ff;
   logic signed [WORD_WIDTH-1:0]  b_value_ff;
   logic signed [WORD_WIDTH-1:0]  b_vec_ff [NUM_ROWS];
   logic signed [ACC_W-1:0]       b_sum_ff [NUM_COLS];
   logic signed [ACC_W-1:0]       b_sum_in [NUM_COLS];

   logic a_en;
   logic b_en;
   logic load_hit;

   assign b_en     = !b_ctl_ff.valid || out_ready;
   assign a_en     = !a_ctl_ff.valid || b_en;
   assign in_ready = a_en;
   assign load_hit = a_en && in_ctl.valid && (in_ctl.kind == REQ_LOAD)
                     && (in_ctl.row == 2'(ROW));

   always_comb begin
      for (int j = 0; j < NUM_COLS; j++) begin
         a_prod_in[j] = in_vec[ROW] * mat_ff[j];
         b_sum_in[j]  = a_sum_ff[j] + ACC_W'(a_prod_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < NUM_COLS; j++) begin
            mat_ff[j] <= (j == ROW) ? ONE : '0;
         end
      end else if (load_hit) begin
         mat_ff[in_ctl.col] <= in_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ctl_ff <= '0;
         b_ctl_ff <= '0;
      end else begin
         if (a_en) begin
            a_ctl_ff <= in_ctl;
         end
         if (b_en) begin
            b_ctl_ff <= a_ctl_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (a_en) begin
         a_value_ff <= in_value;
         a_vec_ff   <= in_vec;
         a_sum_ff   <= in_sum;
         a_prod_ff  <= a_prod_in;
      end
      if (b_en) begin
         b_value_ff <= a_value_ff;
         b_vec_ff   <= a_vec_ff;
         b_sum_ff   <= b_sum_in;
      end
   end

   assign out_ctl   = b_ctl_ff;
   assign out_value = b_value_ff;
   assign out_vec   = b_vec_ff;
   assign out_sum   = b_sum_ff;

endmodule

// ===== hdl/vmt_sat.sv =====
// ----------------------------------------------------------------------------
// vmt_sat: rescale, saturate and hold the result
// Arithmetic shift of the column sums by FRAC_BITS, clip to the word range,
// and register the result vector. Load items are dropped here.
// ----------------------------------------------------------------------------
module vmt_sat
   import vmt_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  ctl_type                        in_ctl,
   input  logic signed [2*WORD_WIDTH+1:0] in_sum [NUM_COLS],
   output logic                           in_ready,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [WORD_WIDTH-1:0]   rsp_res [NUM_COLS],
   output logic                           rsp_ovf
);

   localparam int ACC_W = 2 * WORD_WIDTH + 2;
   localparam logic signed [WORD_WIDTH-1:0] SAT_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] SAT_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   logic                          valid_ff;
   logic signed [WORD_WIDTH-1:0]  res_ff [NUM_COLS];
   logic signed [WORD_WIDTH-1:0]  res_in [NUM_COLS];
   logic                          ovf_ff;
   logic                          ovf_in;
   logic                          en;

   assign en       = !valid_ff || rsp_ready;
   assign in_ready = en;

   always_comb begin
      logic signed [ACC_W-1:0] shifted;
      logic [ACC_W-WORD_WIDTH:0] top;
      logic clip;
      ovf_in = 1'b0;
      for (int j = 0; j < NUM_COLS; j++) begin
         shifted = in_sum[j] >>> FRAC_BITS;
         // fits when everything from the word's sign bit upward agrees
         top  = shifted[ACC_W-1:WORD_WIDTH-1];
         clip = !((&top) || !(|top));
         if (clip) begin
            res_in[j] = shifted[ACC_W-1] ? SAT_MIN : SAT_MAX;
         end else begin
            res_in[j] = shifted[WORD_WIDTH-1:0];
         end
         ovf_in = ovf_in | clip;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_ctl.valid && (in_ctl.kind == REQ_XFORM);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         res_ff <= res_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;
   assign rsp_ovf   = ovf_ff;

endmodule

// ===== hdl/vector_matrix_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// vector_matrix_transform_4x4: row vector times stored 4x4 matrix, fixed point
// out[j] = sum over k of v[k]*M[k][j], summed at full width, shifted right by
// FRAC_BITS and saturated. Matrix resets to identity; load items write one
// entry and give no result.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_ready  kind, entry row/col/value, vector
//   rsp_      out        rsp_valid/rsp_ready  transformed vector, overflow
//
// One item per cycle sustained while the output is not blocked; a transform result
// passes two register stages in each of the four row cells, then the output
// register. Each cell has one column multiplier per column, feeding its
// multiply/accumulate stages.
// Reset restores the identity matrix.
// Ready runs combinationally down the whole chain: a blocked output holds every
// full stage at once, empty stages keep filling, and the input stalls only when
// all nine registers hold an item.
// ----------------------------------------------------------------------------
module vector_matrix_transform_4x4
   import vmt_pkg::*;
#(
   parameter int WORD_WIDTH = WORD_WIDTH_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_type,
   input  logic [1:0]                   req_entry_row,
   input  logic [1:0]                   req_entry_col,
   input  logic signed [WORD_WIDTH-1:0] req_entry_value,
   input  logic signed [WORD_WIDTH-1:0] req_vec_x,
   input  logic signed [WORD_WIDTH-1:0] req_vec_y,
   input  logic signed [WORD_WIDTH-1:0] req_vec_z,
   input  logic signed [WORD_WIDTH-1:0] req_vec_w,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [WORD_WIDTH-1:0] rsp_out_x,
   output logic signed [WORD_WIDTH-1:0] rsp_out_y,
   output logic signed [WORD_WIDTH-1:0] rsp_out_z,
   output logic signed [WORD_WIDTH-1:0] rsp_out_w,
   output logic                         rsp_overflow
);

   localparam int ACC_W = 2 * WORD_WIDTH + 2;
   localparam logic signed [WORD_WIDTH-1:0] SAT_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
   localparam logic signed [WORD_WIDTH-1:0] SAT_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

   ctl_type                      ctl_c   [NUM_ROWS+1];
   logic signed [WORD_WIDTH-1:0] value_c [NUM_ROWS+1];
   logic signed [WORD_WIDTH-1:0] vec_c   [NUM_ROWS+1][NUM_ROWS];
   logic signed [ACC_W-1:0]      sum_c   [NUM_ROWS+1][NUM_COLS];
   logic                         ready_c [NUM_ROWS+1];
   logic signed [WORD_WIDTH-1:0] res     [NUM_COLS];

   assign ctl_c[0].valid = req_valid;
   assign ctl_c[0].kind  = req_kind_type'(req_type);
   assign ctl_c[0].row   = req_entry_row;
   assign ctl_c[0].col   = req_entry_col;
   assign value_c[0]     = req_entry_value;
   assign vec_c[0][0]    = req_vec_x;
   assign vec_c[0][1]    = req_vec_y;
   assign vec_c[0][2]    = req_vec_z;
   assign vec_c[0][3]    = req_vec_w;

   for (genvar j = 0; j < NUM_COLS; j++) begin : g_sum0
      assign sum_c[0][j] = '0;
   end

   assign req_ready = ready_c[0];

   for (genvar k = 0; k < NUM_ROWS; k++) begin : g_cell
      vmt_cell #(
         .WORD_WIDTH (WORD_WIDTH),
         .FRAC_BITS  (FRAC_BITS),
         .ROW        (k)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_ctl    (ctl_c[k]),
         .in_value  (value_c[k]),
         .in_vec    (vec_c[k]),
         .in_sum    (sum_c[k]),
         .in_ready  (ready_c[k]),
         .out_ctl   (ctl_c[k+1]),
         .out_value (value_c[k+1]),
         .out_vec   (vec_c[k+1]),
         .out_sum   (sum_c[k+1]),
         .out_ready (ready_c[k+1])
      );
   end

   vmt_sat #(
      .WORD_WIDTH (WORD_WIDTH),
      .FRAC_BITS  (FRAC_BITS)
   ) u_sat (
      .clock     (clock),
      .reset     (reset),
      .in_ctl    (ctl_c[NUM_ROWS]),
      .in_sum    (sum_c[NUM_ROWS]),
      .in_ready  (ready_c[NUM_ROWS]),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_res   (res),
      .rsp_ovf   (rsp_overflow)
   );

   assign rsp_out_x = res[0];
   assign rsp_out_y = res[1];
   assign rsp_out_z = res[2];
   assign rsp_out_w = res[3];

   // the chain only backs up to the input when the output is blocked
   a_stall_only_when_blocked: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("input stalled with output free");

   // an overflow flag needs at least one clipped component
   a_ovf_has_clip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN ||
          rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN ||
          rsp_out_z == SAT_MAX || rsp_out_z == SAT_MIN ||
          rsp_out_w == SAT_MAX || rsp_out_w == SAT_MIN))
      else $error("overflow without a saturated component");

   // a fresh reset leaves the pipe empty and ready
   a_ready_after_reset: assert property (@(posedge clock)
      $past(reset) && !reset |-> (req_ready && !rsp_valid))
      else $error("pipeline not empty after reset");

endmodule

// ===== tb/sv/vmt_transform_scoreboard_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_transform_scoreboard_pkg: expected-result tracking for the 4x4 transform
// Keeps a private copy of the matrix, works out each transform result in
// Q16.16 and compares the block's results against them in order.
// ----------------------------------------------------------------------------
package vmt_transform_scoreboard_pkg;
   import vmt_pkg::*;

   localparam int W    = WORD_WIDTH_DEF;
   localparam int FRAC = FRAC_BITS_DEF;

   typedef logic signed [W-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(W-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(W-1){1'b0}}};
   localparam word_type WORD_ONE = word_type'(1) << FRAC;

   // limits of a word-sized component, held at the wide accumulator's width
   localparam logic signed [2*W+1:0] WIDE_MAX = {{(W+3){1'b0}}, {(W-1){1'b1}}};
   localparam logic signed [2*W+1:0] WIDE_MIN = -WIDE_MAX - 1;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
      word_type w;
      logic     ovf;
   } xform_result_type;

   class vmt_transform_scoreboard;
      word_type         matrix[16];
      xform_result_type expected_q[$];
      int unsigned      n_errors;
      int unsigned      n_loads;
      int unsigned      n_xforms;
      int unsigned      n_saturated;
      int unsigned      n_checked;

      function new();
         for (int i = 0; i < 16; i++) begin
            matrix[i] = (i % 5 == 0) ? WORD_ONE : '0;
         end
         n_errors    = 0;
         n_loads     = 0;
         n_xforms    = 0;
         n_saturated = 0;
         n_checked   = 0;
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      // out[j] = sum_k v[k]*M[k][j], exact sum, arithmetic shift, clip to a word
      function xform_result_type transform_vector(word_type vx, word_type vy,
                                                  word_type vz, word_type vw);
         word_type                vec[4];
         word_type                comp[4];
         logic signed [2*W-1:0]   prod;
         logic signed [2*W+1:0]   acc;
         logic signed [2*W+1:0]   shifted;
         xform_result_type        r;
         vec[0] = vx;
         vec[1] = vy;
         vec[2] = vz;
         vec[3] = vw;
         r.ovf  = 1'b0;
         for (int j = 0; j < 4; j++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               prod = vec[k] * matrix[k*4 + j];
               acc  = acc + prod;
            end
            shifted = acc >>> FRAC;
            if (shifted > WIDE_MAX) begin
               comp[j] = WORD_MAX;
               r.ovf   = 1'b1;
            end else if (shifted < WIDE_MIN) begin
               comp[j] = WORD_MIN;
               r.ovf   = 1'b1;
            end else begin
               comp[j] = shifted[W-1:0];
            end
         end
         r.x = comp[0];
         r.y = comp[1];
         r.z = comp[2];
         r.w = comp[3];
         return r;
      endfunction

      function void note_request(req_kind_type kind, logic [1:0] row, logic [1:0] col,
                                 word_type value, word_type vx, word_type vy,
                                 word_type vz, word_type vw);
         xform_result_type r;
         if (kind == REQ_LOAD) begin
            matrix[{row, col}] = value;
            n_loads++;
         end else begin
            r = transform_vector(vx, vy, vz, vw);
            if (r.ovf) n_saturated++;
            n_xforms++;
            expected_q.push_back(r);
         end
      endfunction

      function void compare_field(string name, word_type want, word_type got);
         if (want !== got) begin
            n_errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         end
      endfunction

      function void check_result(xform_result_type got);
         xform_result_type want;
         n_checked++;
         if (expected_q.size() == 0) begin
            n_errors++;
            $display("%0t: unexpected result, expected none, got %h %h %h %h ovf %b",
                     $time, got.x, got.y, got.z, got.w, got.ovf);
            return;
         end
         want = expected_q.pop_front();
         compare_field("out_x", want.x, got.x);
         compare_field("out_y", want.y, got.y);
         compare_field("out_z", want.z, got.z);
         compare_field("out_w", want.w, got.w);
         compare_field("overflow", word_type'(want.ovf), word_type'(got.ovf));
      endfunction
   endclass

endpackage

// ===== tb/sv/tb_vector_matrix_transform_4x4.sv =====
// ----------------------------------------------------------------------------
// tb_vector_matrix_transform_4x4: self-checking bench for the 4x4 transform
// Directed corner items first (identity, saturation both ways, truncation,
// full-width sums), then phases that load a whole matrix and stream mixed
// loads and transforms, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_vector_matrix_transform_4x4;
   import vmt_pkg::*;
   import vmt_transform_scoreboard_pkg::*;

   typedef enum int {
      VAL_MIXED,
      VAL_SMALL,
      VAL_FULL,
      VAL_CORNER
   } value_style_type;

   localparam int SETTLE_CYCLES = 16;
   localparam int ITEMS_PER_PHASE = 180;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_type = 1'b0;
   logic [1:0] req_entry_row = '0;
   logic [1:0] req_entry_col = '0;
   word_type   req_entry_value = '0;
   word_type   req_vec_x = '0;
   word_type   req_vec_y = '0;
   word_type   req_vec_z = '0;
   word_type   req_vec_w = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   word_type   rsp_out_x;
   word_type   rsp_out_y;
   word_type   rsp_out_z;
   word_type   rsp_out_w;
   logic       rsp_overflow;

   bit tx_idle = 1'b0;
   bit rx_idle = 1'b1;

   vmt_transform_scoreboard sb = new();

   vector_matrix_transform_4x4 dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_type        (req_type),
      .req_entry_row   (req_entry_row),
      .req_entry_col   (req_entry_col),
      .req_entry_value (req_entry_value),
      .req_vec_x       (req_vec_x),
      .req_vec_y       (req_vec_y),
      .req_vec_z       (req_vec_z),
      .req_vec_w       (req_vec_w),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_x       (rsp_out_x),
      .rsp_out_y       (rsp_out_y),
      .rsp_out_z       (rsp_out_z),
      .rsp_out_w       (rsp_out_w),
      .rsp_overflow    (rsp_overflow)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic word_type rand_word(value_style_type style);
      logic signed [19:0] frac20;
      value_style_type    s;
      s = style;
      if (s == VAL_MIXED) begin
         case ($urandom_range(0, 19)) inside
            [0:2]:   s = VAL_CORNER;
            [3:7]:   s = VAL_FULL;
            default: s = VAL_SMALL;
         endcase
      end
      case (s)
         VAL_FULL:   return word_type'($urandom);
         VAL_CORNER: begin
            case ($urandom_range(0, 7))
               0:       return WORD_MAX;
               1:       return WORD_MIN;
               2:       return '0;
               3:       return WORD_ONE;
               4:       return -WORD_ONE;
               5:       return word_type'(1);
               6:       return -word_type'(1);
               default: return WORD_ONE >>> 1;
            endcase
         end
         default: begin
            // magnitude at most 8.0, sign extended
            frac20 = 20'($urandom);
            return word_type'(frac20);
         end
      endcase
   endfunction

   task automatic send_item(req_kind_type kind, logic [1:0] row, logic [1:0] col,
                            word_type value, word_type vx, word_type vy,
                            word_type vz, word_type vw);
      int gap;
      gap = tx_idle ? $urandom_range(0, 19) : 0;
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_entry_row   <= row;
      req_entry_col   <= col;
      req_entry_value <= value;
      req_vec_x       <= vx;
      req_vec_y       <= vy;
      req_vec_z       <= vz;
      req_vec_w       <= vw;
      do @(posedge clock); while (!req_ready);
      sb.note_request(kind, row, col, value, vx, vy, vz, vw);
   endtask

   // vector fields carry noise on a load
   task automatic load_entry(logic [1:0] row, logic [1:0] col, word_type value);
      send_item(REQ_LOAD, row, col, value, rand_word(VAL_FULL), rand_word(VAL_FULL),
                rand_word(VAL_FULL), rand_word(VAL_FULL));
   endtask

   // entry fields carry noise on a transform
   task automatic apply_vector(word_type vx, word_type vy, word_type vz, word_type vw);
      send_item(REQ_XFORM, 2'($urandom), 2'($urandom), rand_word(VAL_FULL), vx, vy, vz, vw);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // result side
   initial begin
      int gap;
      xform_result_type got;
      while (reset) @(negedge clock);
      forever begin
         gap = rx_idle ? $urandom_range(0, 19) : 0;
         repeat (gap) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         got = '{x: rsp_out_x, y: rsp_out_y, z: rsp_out_z, w: rsp_out_w, ovf: rsp_overflow};
         sb.check_result(got);
      end
   end

   initial begin
      value_style_type mat_style;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity after reset, zero vector
      apply_vector(WORD_ONE, -WORD_ONE, WORD_MAX, WORD_MIN);
      apply_vector('0, '0, '0, '0);
      // saturation up and down
      load_entry(2'd0, 2'd0, WORD_MAX);
      apply_vector(WORD_MAX, '0, '0, '0);
      apply_vector(WORD_MIN, '0, '0, '0);
      load_entry(2'd3, 2'd3, WORD_MIN);
      apply_vector('0, '0, '0, WORD_MIN);
      apply_vector('0, '0, '0, WORD_MAX);
      // shift truncates toward minus infinity
      load_entry(2'd2, 2'd2, word_type'(1));
      apply_vector('0, '0, -word_type'(1), '0);
      apply_vector('0, '0, word_type'(1), '0);
      load_entry(2'd0, 2'd3, -WORD_ONE);
      load_entry(2'd3, 2'd0, WORD_ONE >>> 1);
      load_entry(2'd1, 2'd2, -word_type'(1));
      apply_vector(WORD_ONE, WORD_ONE, WORD_ONE, WORD_ONE);
      // four products at the top of their range: sum needs more than 64 bits
      for (int k = 0; k < 4; k++) begin
         load_entry(2'(k), 2'd1, WORD_MIN);
      end
      apply_vector(WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
      apply_vector(WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      apply_vector(WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX);
      load_entry(2'd0, 2'd0, WORD_ONE);
      load_entry(2'd3, 2'd3, WORD_ONE);
      apply_vector(rand_word(VAL_SMALL), rand_word(VAL_SMALL),
                   rand_word(VAL_SMALL), rand_word(VAL_SMALL));
      drain();

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       mat_style = VAL_SMALL;
            1:       mat_style = VAL_MIXED;
            2:       mat_style = VAL_CORNER;
            default: mat_style = VAL_FULL;
         endcase
         // phase 2 runs flat out on both sides
         tx_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
         rx_idle = (phase != 2) && ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 16; i++) begin
            load_entry(2'(i >> 2), 2'(i), rand_word(mat_style));
         end
         repeat (ITEMS_PER_PHASE) begin
            if ($urandom_range(0, 4) == 0)
               load_entry(2'($urandom), 2'($urandom), rand_word(VAL_MIXED));
            else
               apply_vector(rand_word(VAL_MIXED), rand_word(VAL_MIXED),
                            rand_word(VAL_MIXED), rand_word(VAL_MIXED));
         end
         // hold the sender until the pipe is empty
         drain();
      end

      $display("Covered %0d entry loads and %0d transforms (%0d saturating),",
               sb.n_loads, sb.n_xforms, sb.n_saturated);
      $display("with %0d results checked under random idling on both channels.",
               sb.n_checked);
      if (sb.n_errors == 0 && sb.pending() == 0) begin
         $display("vector_matrix_transform_4x4 test passed");
      end else begin
         $display("vector_matrix_transform_4x4 test failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("%0t: timeout with %0d results outstanding", $time, sb.pending());
      $display("vector_matrix_transform_4x4 test failed");
      $finish;
   end

endmodule
